// ----- hdl/slfs_pkg.sv -----
// ----------------------------------------------------------------------------
// slfs_pkg
// Types, register codes and helpers shared by the status LED flash sequencer.
// ----------------------------------------------------------------------------
package slfs_pkg;

  localparam int unsigned MaxFlashes = 3;
  localparam int unsigned CntW       = 16;
  localparam int unsigned TickW      = 32;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned FlashW     = 2;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CntW-1:0] FlashOnRst    = 16'd200;
  localparam logic [CntW-1:0] FlashGapRst   = 16'd200;
  localparam logic [CntW-1:0] SeqGapRst     = 16'd1000;
  localparam logic [CntW-1:0] OvrPeriodRst  = 16'd100;
  localparam logic [CntW-1:0] BcastPeriodRst = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLASH_ON     = 3'd0,
    CFG_FLASH_GAP    = 3'd1,
    CFG_SEQ_GAP      = 3'd2,
    CFG_OVR_PERIOD   = 3'd3,
    CFG_BCAST_PERIOD = 3'd4,
    CFG_BCAST_EN     = 3'd5
  } cfg_idx_e;

  typedef enum logic [CodeW-1:0] {
    ST_INIT        = 3'd0,
    ST_OPERATIONAL = 3'd1,
    ST_WARNING     = 3'd2,
    ST_BUS_OFF     = 3'd3,
    ST_DFU         = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_FLASH_ON  = 3'd1,
    PH_FLASH_GAP = 3'd2,
    PH_SEQ_GAP   = 3'd3,
    PH_INIT_ON   = 3'd4,
    PH_INIT_OFF  = 3'd5,
    PH_SINGLE    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [CntW-1:0] flash_on;
    logic [CntW-1:0] flash_gap;
    logic [CntW-1:0] seq_gap;
    logic [CntW-1:0] ovr_period;
    logic [CntW-1:0] bcast_period;
    logic            bcast_en;
  } cfg_t;

  typedef struct packed {
    logic             led_lit;
    logic             bcast_valid;
    logic [CodeW-1:0] bcast_status;
  } result_t;

  // A zero length segment still lasts one tick.
  function automatic logic [CntW-1:0] seg_len(input logic [CntW-1:0] v);
    seg_len = (v == '0) ? CntW'(1) : v;
  endfunction

  function automatic logic [FlashW-1:0] flash_target(input logic [CodeW-1:0] code);
    logic [FlashW-1:0] n;
    n = '0;
    unique case (code)
      ST_OPERATIONAL: n = FlashW'(1);
      ST_WARNING:     n = FlashW'(2);
      ST_DFU:         n = FlashW'(3);
      default:        n = '0;
    endcase
    if (32'(n) > MaxFlashes) n = FlashW'(MaxFlashes);
    flash_target = n;
  endfunction

endpackage

// ----- hdl/slfs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// slfs_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module slfs_cfg_regs import slfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CfgIdxW-1:0]   wr_idx_i,
  input  logic [CntW-1:0]      wr_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_FLASH_ON:     cfg_d.flash_on     = wr_data_i;
        CFG_FLASH_GAP:    cfg_d.flash_gap    = wr_data_i;
        CFG_SEQ_GAP:      cfg_d.seq_gap      = wr_data_i;
        CFG_OVR_PERIOD:   cfg_d.ovr_period   = wr_data_i;
        CFG_BCAST_PERIOD: cfg_d.bcast_period = wr_data_i;
        CFG_BCAST_EN:     cfg_d.bcast_en     = wr_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_on     <= FlashOnRst;
      cfg_q.flash_gap    <= FlashGapRst;
      cfg_q.seq_gap      <= SeqGapRst;
      cfg_q.ovr_period   <= OvrPeriodRst;
      cfg_q.bcast_period <= BcastPeriodRst;
      cfg_q.bcast_en     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/slfs_core.sv -----
// ----------------------------------------------------------------------------
// slfs_core
// Pattern state and the per-tick update that yields the LED level and the
// broadcast decision in a single pass.
// ----------------------------------------------------------------------------
module slfs_core import slfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic [CodeW-1:0] code_i,
  input  logic             ovr_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  logic              led_q, led_d;
  logic [CodeW-1:0]  latched_q, latched_d;
  phase_e            phase_q, phase_d;
  logic [FlashW-1:0] flashes_q, flashes_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovr_q, ovr_d;
  logic [TickW-1:0]  uptime_q, uptime_d;
  logic [TickW-1:0]  last_q, last_d;
  logic [TickW-1:0]  elapsed;
  logic [FlashW-1:0] flashes_inc;
  logic              bcast_fire;

  always_comb begin
    led_d       = led_q;
    latched_d   = latched_q;
    phase_d     = phase_q;
    flashes_d   = flashes_q;
    cnt_d       = cnt_q;
    ovr_d       = ovr_i;
    last_d      = last_q;
    uptime_d    = uptime_q + TickW'(1);
    bcast_fire  = 1'b0;
    flashes_inc = flashes_q + FlashW'(1);
    elapsed     = uptime_d - last_q;

    // An override change takes effect before the segment logic.
    if (ovr_i != ovr_q) begin
      if (ovr_i) begin
        led_d   = 1'b1;
        phase_d = PH_START;
        cnt_d   = '0;
      end else begin
        led_d = 1'b0;
      end
    end

    if (cnt_d == '0) begin
      unique case (phase_d)
        PH_FLASH_ON: begin
          led_d     = 1'b0;
          flashes_d = flashes_inc;
          if (flashes_inc < flash_target(latched_q)) begin
            phase_d = PH_FLASH_GAP;
            cnt_d   = seg_len(cfg_i.flash_gap);
          end else begin
            phase_d = PH_SEQ_GAP;
            cnt_d   = seg_len(cfg_i.seq_gap);
          end
        end
        PH_FLASH_GAP: begin
          led_d   = 1'b1;
          phase_d = PH_FLASH_ON;
          cnt_d   = seg_len(cfg_i.flash_on);
        end
        PH_INIT_ON: begin
          led_d   = 1'b0;
          phase_d = PH_INIT_OFF;
          cnt_d   = seg_len(cfg_i.flash_gap);
        end
        default: begin
          // Start of a new pattern: latch the requested code.
          latched_d = code_i;
          flashes_d = '0;
          cnt_d     = seg_len(cfg_i.flash_on);
          if (ovr_i) begin
            led_d   = 1'b1;
            phase_d = PH_SINGLE;
            cnt_d   = seg_len(cfg_i.ovr_period);
          end else begin
            unique case (code_i) inside
              ST_INIT: begin
                led_d   = 1'b1;
                phase_d = PH_INIT_ON;
              end
              ST_OPERATIONAL, ST_WARNING, ST_DFU: begin
                led_d   = 1'b1;
                phase_d = PH_FLASH_ON;
              end
              ST_BUS_OFF: begin
                led_d   = 1'b1;
                phase_d = PH_SINGLE;
              end
              default: phase_d = PH_SINGLE;
            endcase
          end
        end
      endcase
    end

    cnt_d = cnt_d - CntW'(1);

    if (cnt_d == '0 &&
        (phase_d == PH_SEQ_GAP || phase_d == PH_INIT_OFF || phase_d == PH_SINGLE)) begin
      phase_d = PH_START;
      if (cfg_i.bcast_en && elapsed >= TickW'(cfg_i.bcast_period)) begin
        bcast_fire = 1'b1;
        last_d     = uptime_d;
      end
    end
  end

  always_comb begin
    res_o         = '0;
    res_o.led_lit = led_d;
    if (bcast_fire) begin
      res_o.bcast_valid  = 1'b1;
      res_o.bcast_status = latched_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q     <= 1'b0;
      latched_q <= ST_INIT;
      phase_q   <= PH_START;
      flashes_q <= '0;
      cnt_q     <= '0;
      ovr_q     <= 1'b0;
      uptime_q  <= '0;
      last_q    <= '0;
    end else if (tick_i) begin
      led_q     <= led_d;
      latched_q <= latched_d;
      phase_q   <= phase_d;
      flashes_q <= flashes_d;
      cnt_q     <= cnt_d;
      ovr_q     <= ovr_d;
      uptime_q  <= uptime_d;
      last_q    <= last_d;
    end
  end

endmodule

// ----- hdl/status_led_flash_sequencer.sv -----
// ----------------------------------------------------------------------------
// status_led_flash_sequencer
// Tick-driven status LED pattern generator with periodic status broadcast.
// ----------------------------------------------------------------------------
// The result word is registered and shows in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle; the pattern update is a single
// counter and compare pass into the output register.
// A waiting result blocks input only when the downstream side stalls.
// Reset (asynchronous, active low) restores register defaults and waits at
// the start of a pattern with the LED off; the first tick latches its code.
// ----------------------------------------------------------------------------
module status_led_flash_sequencer import slfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [2:0] status_code, [3] override_on
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // [0] led_lit, [1] broadcast_valid,
                                               // [4:2] broadcast_status
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CntW-1:0]    cfg_data_i
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    tick;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign tick            = s_axis_tvalid_i && s_axis_tready_o;

  slfs_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  slfs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .code_i (s_axis_tdata_i[2:0]),
    .ovr_i  (s_axis_tdata_i[3]),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q.bcast_status, res_q.bcast_valid, res_q.led_lit};

endmodule
